// ===== rtl/glob_pattern_matcher_macros.svh =====
// Assertion macros shared by the glob pattern matcher RTL.
`ifndef GLOB_PATTERN_MATCHER_MACROS_SVH
`define GLOB_PATTERN_MATCHER_MACROS_SVH

// Checked on every rising edge of clk, ignored while rst_n is low.
`define GPM_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked on every rising edge of clk, reset included.
`define GPM_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/gpm_pkg.sv =====
// ----------------------------------------------------------------------------
// gpm_pkg
// Constants, types and the star closure function of the glob pattern matcher.
// ----------------------------------------------------------------------------
package gpm_pkg;

  localparam int PATTERN_MAX = 16;
  localparam int POS_W       = PATTERN_MAX + 1;
  localparam int LEN_W       = $clog2(POS_W);
  localparam int CLOSE_LVL   = $clog2(POS_W);

  localparam int CFG_DATA_W  = 64;
  localparam int CFG_ADDR_W  = 5;
  localparam int CFG_LEN_W   = 5;

  localparam logic [7:0] CH_STAR  = 8'h2A;
  localparam logic [7:0] CH_QUEST = 8'h3F;
  localparam logic [7:0] CH_DOT   = 8'h2E;

  typedef logic [POS_W-1:0]             pos_set_t;
  typedef logic [PATTERN_MAX-1:0][7:0]  pattern_t;

  typedef enum logic [1:0] {
    REG_CHARS_LOW  = 2'd0,
    REG_CHARS_HIGH = 2'd1,
    REG_LENGTH     = 2'd2
  } cfg_reg_t;

  // Pattern as seen by the matching logic, length already clamped.
  typedef struct packed {
    pattern_t              chars;
    logic [LEN_W-1:0]      len;
  } pat_cfg_t;

  // Every active '*' position also activates the one after it, carried
  // through runs of stars with a log-depth prefix.
  function automatic pos_set_t star_closure(pos_set_t set,
                                            logic [PATTERN_MAX-1:0] star);
    pos_set_t g;
    pos_set_t p;
    g = set;
    p = {star, 1'b0};
    for (int l = 0; l < CLOSE_LVL; l++) begin
      g = g | (p & (g << (1 << l)));
      p = p & (p << (1 << l));
    end
    return g;
  endfunction

endpackage

// ===== rtl/gpm_cfg.sv =====
// ----------------------------------------------------------------------------
// gpm_cfg
// APB register file holding the pattern and its length.
// ----------------------------------------------------------------------------
module gpm_cfg (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [gpm_pkg::CFG_ADDR_W-1:0]   paddr,
  input  logic [gpm_pkg::CFG_DATA_W-1:0]   pwdata,
  output logic [gpm_pkg::CFG_DATA_W-1:0]   prdata,
  output logic                             pready,
  output gpm_pkg::pat_cfg_t                pat_cfg
);

  logic [gpm_pkg::CFG_DATA_W-1:0] chars_low_r;
  logic [gpm_pkg::CFG_DATA_W-1:0] chars_high_r;
  logic [gpm_pkg::CFG_LEN_W-1:0]  length_r;
  logic                           wr_en;
  gpm_pkg::cfg_reg_t              reg_sel;

  assign pready  = 1'b1;
  assign wr_en   = psel & penable & pwrite & pready;
  assign reg_sel = gpm_pkg::cfg_reg_t'(paddr[4:3]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      chars_low_r  <= '0;
      chars_high_r <= '0;
      length_r     <= '0;
    end else if (wr_en) begin
      unique case (reg_sel)
        gpm_pkg::REG_CHARS_LOW:  chars_low_r  <= pwdata;
        gpm_pkg::REG_CHARS_HIGH: chars_high_r <= pwdata;
        gpm_pkg::REG_LENGTH:     length_r     <= pwdata[gpm_pkg::CFG_LEN_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      gpm_pkg::REG_CHARS_LOW:  prdata = chars_low_r;
      gpm_pkg::REG_CHARS_HIGH: prdata = chars_high_r;
      gpm_pkg::REG_LENGTH:
        prdata = {{(gpm_pkg::CFG_DATA_W-gpm_pkg::CFG_LEN_W){1'b0}}, length_r};
      default:                 prdata = '0;
    endcase
  end

  // Over-long length saturates at the pattern size.
  always_comb begin
    pat_cfg.chars = gpm_pkg::pattern_t'({chars_high_r, chars_low_r});
    if (length_r > gpm_pkg::CFG_LEN_W'(gpm_pkg::PATTERN_MAX)) begin
      pat_cfg.len = gpm_pkg::LEN_W'(gpm_pkg::PATTERN_MAX);
    end else begin
      pat_cfg.len = gpm_pkg::LEN_W'(length_r);
    end
  end

endmodule

// ===== rtl/gpm_step.sv =====
// ----------------------------------------------------------------------------
// gpm_step
// Next active position set and match bit for one name character.
// ----------------------------------------------------------------------------
module gpm_step (
  input  gpm_pkg::pat_cfg_t  pat_cfg,
  input  gpm_pkg::pos_set_t  act,
  input  logic               at_start,
  input  logic [7:0]         char_code,
  input  logic               has_char,
  output gpm_pkg::pos_set_t  act_nxt,
  output logic               at_start_nxt,
  output logic               matched
);

  logic [gpm_pkg::PATTERN_MAX-1:0] star;
  logic [gpm_pkg::PATTERN_MAX-1:0] hit;
  gpm_pkg::pos_set_t               closed;
  gpm_pkg::pos_set_t               adv;
  gpm_pkg::pos_set_t               final_set;
  logic                            dot_block;

  always_comb begin
    for (int i = 0; i < gpm_pkg::PATTERN_MAX; i++) begin
      logic in_len;
      logic is_star;
      in_len  = gpm_pkg::LEN_W'(i) < pat_cfg.len;
      is_star = pat_cfg.chars[i] == gpm_pkg::CH_STAR;
      star[i] = in_len & is_star;
      hit[i]  = in_len & ~is_star &
                ((pat_cfg.chars[i] == gpm_pkg::CH_QUEST) ||
                 (pat_cfg.chars[i] == char_code));
    end
  end

  assign closed = gpm_pkg::star_closure(act, star);
  // '*' keeps its position, a literal or '?' hit moves one on.
  assign adv = {1'b0, closed[gpm_pkg::PATTERN_MAX-1:0] & star} |
               {closed[gpm_pkg::PATTERN_MAX-1:0] & hit, 1'b0};

  // Hidden names need a leading dot in the pattern.
  assign dot_block = at_start && (char_code == gpm_pkg::CH_DOT) &&
                     ((pat_cfg.len == '0) || (pat_cfg.chars[0] != gpm_pkg::CH_DOT));

  always_comb begin
    if (!has_char) begin
      act_nxt = act;
    end else if (dot_block) begin
      act_nxt = '0;
    end else begin
      act_nxt = adv;
    end
  end

  assign at_start_nxt = at_start & ~has_char;
  assign final_set    = gpm_pkg::star_closure(act_nxt, star);
  assign matched      = final_set[pat_cfg.len];

endmodule

// ===== rtl/glob_pattern_matcher.sv =====
// ----------------------------------------------------------------------------
// glob_pattern_matcher
// Streams a name one byte per word and flags whether it matches a glob pattern.
// ----------------------------------------------------------------------------
// The pattern (up to 16 bytes, '*' any run, '?' any one byte, others literal)
// and its length are written over the APB port at byte addresses 0, 8 and 16;
// lengths above 16 act as 16. Each input word carries one name byte (has_char)
// and/or the end-of-name mark (name_end); only an end word yields a result
// word, out_matched. A name starting with '.' matches only a pattern starting
// with '.'. Throughput is one word per cycle while in_stall is low: a word is
// held in the input register, the position-set update (a 17-bit set with a
// log-depth star closure) runs on it there, and an end word's result lands in
// the output register, which holds out_valid high until the result word is
// taken. in_stall only rises when an end word meets a full, stalled output
// register.
// ----------------------------------------------------------------------------
`include "glob_pattern_matcher_macros.svh"

module glob_pattern_matcher (
  input  logic                             clk,
  input  logic                             rst_n,
  // input channel
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic [7:0]                       in_char_code,
  input  logic                             in_has_char,
  input  logic                             in_name_end,
  // result channel
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic                             out_matched,
  // configuration
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [gpm_pkg::CFG_ADDR_W-1:0]   paddr,
  input  logic [gpm_pkg::CFG_DATA_W-1:0]   pwdata,
  output logic [gpm_pkg::CFG_DATA_W-1:0]   prdata,
  output logic                             pready
);

  gpm_pkg::pat_cfg_t pat_cfg;

  // input register
  logic       s1_vld_r;
  logic [7:0] s1_char_r;
  logic       s1_has_r;
  logic       s1_end_r;

  // match state
  gpm_pkg::pos_set_t act_r;
  logic              at_start_r;

  // output register
  logic out_vld_r;
  logic out_matched_r;

  gpm_pkg::pos_set_t act_nxt;
  logic              at_start_nxt;
  logic              step_match;
  logic              s1_go;
  logic              out_take;

  gpm_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .pat_cfg (pat_cfg)
  );

  gpm_step u_step (
    .pat_cfg      (pat_cfg),
    .act          (act_r),
    .at_start     (at_start_r),
    .char_code    (s1_char_r),
    .has_char     (s1_has_r),
    .act_nxt      (act_nxt),
    .at_start_nxt (at_start_nxt),
    .matched      (step_match)
  );

  // An end word can only leave the input register if the output slot is free
  // or being emptied this cycle; other words always pass.
  assign out_take = out_vld_r & ~out_stall;
  assign s1_go    = s1_vld_r & (~s1_end_r | ~out_vld_r | ~out_stall);
  assign in_stall = s1_vld_r & ~s1_go;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else if (!in_stall) begin
      s1_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s1_char_r <= in_char_code;
      s1_has_r  <= in_has_char;
      s1_end_r  <= in_name_end;
    end
  end

  // The set goes back to position zero once a name ends.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      act_r      <= gpm_pkg::POS_W'(1);
      at_start_r <= 1'b1;
    end else if (s1_go) begin
      if (s1_end_r) begin
        act_r      <= gpm_pkg::POS_W'(1);
        at_start_r <= 1'b1;
      end else begin
        act_r      <= act_nxt;
        at_start_r <= at_start_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (s1_go && s1_end_r) begin
      out_vld_r <= 1'b1;
    end else if (out_take) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go && s1_end_r) begin
      out_matched_r <= step_match;
    end
  end

  assign out_valid   = out_vld_r;
  assign out_matched = out_matched_r;

  // An end word that leaves the input register always yields a result word.
  `GPM_ASSERT(a_end_gives_result, s1_go && s1_end_r |=> out_vld_r, "end word lost its result")
  // State is back at the start of a name after an end word.
  `GPM_ASSERT(a_end_resets_state,
              s1_go && s1_end_r |=> (act_r == gpm_pkg::POS_W'(1)) && at_start_r,
              "state not restored after name end")
  // A name byte clears the name-start flag.
  `GPM_ASSERT(a_char_clears_start,
              s1_go && s1_has_r && !s1_end_r |=> !at_start_r,
              "name start flag still set after a byte")
  // An end word facing a full, stalled output must hold the input side.
  `GPM_ASSERT_ALWAYS(a_end_blocked_holds,
                     s1_vld_r && s1_end_r && out_vld_r && out_stall |-> in_stall,
                     "end word overran a stalled result")

endmodule
